// ===== rtl/core/etpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Event-triggered pin pulser package
// Action codes, register indexes, field widths and the mode-to-event table.
// ----------------------------------------------------------------------------
package etpp_pkg;

  localparam int ACTION_W    = 2;
  localparam int EVENT_W     = 4;
  localparam int PINS_W      = 8;
  localparam int MODE_W      = 6;
  localparam int DUR_W       = 10;
  localparam int TPM_W       = 16;
  localparam int PROD_W      = DUR_W + TPM_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  typedef logic [ACTION_W-1:0]    action_t;
  typedef logic [EVENT_W-1:0]     event_t;
  typedef logic [MODE_W-1:0]      mode_t;
  typedef logic [DUR_W-1:0]       dur_t;
  typedef logic [2**EVENT_W-1:0]  event_set_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam action_t ACT_TICK   = 2'd0;
  localparam action_t ACT_EVENT  = 2'd1;
  localparam action_t ACT_REINIT = 2'd2;

  localparam cfg_index_t REG_MODE_TABLE = 3'd0;
  localparam cfg_index_t REG_DUR_LOW    = 3'd1;
  localparam cfg_index_t REG_DUR_HIGH   = 3'd2;
  localparam cfg_index_t REG_IDLE_MASK  = 3'd3;
  localparam cfg_index_t REG_TICKS_MS   = 3'd4;

  localparam mode_t MODE_FIRST      = 6'd10;
  localparam mode_t MODE_LAST       = 6'd28;
  localparam dur_t  MAX_DURATION_MS = 10'd1000;

  function automatic event_set_t mode_events(input mode_t mode);
    event_set_t set;
    unique case (mode)
      6'd10:   set = 16'h0001;
      6'd11:   set = 16'h0002;
      6'd12:   set = 16'h0004;
      6'd13:   set = 16'h0003;
      6'd14:   set = 16'h0007;
      6'd15:   set = 16'h0008;
      6'd16:   set = 16'h0010;
      6'd17:   set = 16'h0020;
      6'd18:   set = 16'h0040;
      6'd19:   set = 16'h0030;
      6'd20:   set = 16'h0070;
      6'd21:   set = 16'h0011;
      6'd22:   set = 16'h0022;
      6'd23:   set = 16'h0044;
      6'd24:   set = 16'h0033;
      6'd25:   set = 16'h0077;
      6'd26:   set = 16'h0080;
      6'd27:   set = 16'h0100;
      6'd28:   set = 16'h0200;
      default: set = '0;
    endcase
    return set;
  endfunction

endpackage

// ===== rtl/core/event_triggered_pin_pulser_top.sv =====
// ----------------------------------------------------------------------------
// Event-triggered pin pulser
// Per-pin update logic feeds the output result register, or the skid register
// when the output is held. Throughput: one item per cycle while not stalled.
// A skid register holds one extra result, so input stalls only when it is full.
// Reset clears levels, timers and handshake state; result data regs are not reset.
// ----------------------------------------------------------------------------
module event_triggered_pin_pulser_top
  import etpp_pkg::*;
#(
  parameter int PIN_COUNT   = 8,
  parameter int COUNT_WIDTH = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ACTION_W-1:0]   action,
  input  logic [EVENT_W-1:0]    event_code,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PINS_W-1:0]     pin_levels,
  output logic [PINS_W-1:0]     timers_running
);

  localparam int CALC_W = (COUNT_WIDTH > PROD_W) ? COUNT_WIDTH : PROD_W;

  logic [CFG_DATA_W-1:0] mode_table;
  logic [4*DUR_W-1:0]    durations_pins_low;
  logic [4*DUR_W-1:0]    durations_pins_high;
  logic [PINS_W-1:0]     idle_mask;
  logic [TPM_W-1:0]      ticks_per_ms;

  logic [PINS_W-1:0] levels;
  wire  [PINS_W-1:0] levels_next;
  logic [PINS_W-1:0] armed;
  wire  [PINS_W-1:0] armed_next;

  logic [PINS_W-1:0] skid_levels;
  logic [PINS_W-1:0] skid_armed;
  logic              skid_valid;

  logic [8*DUR_W-1:0] dur_all;
  logic               in_xfer;
  logic               out_xfer;

  assign dur_all  = {durations_pins_high, durations_pins_low};
  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_table          <= '0;
      durations_pins_low  <= '0;
      durations_pins_high <= '0;
      idle_mask           <= '0;
      ticks_per_ms        <= TPM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE_TABLE: mode_table          <= cfg_data;
        REG_DUR_LOW:    durations_pins_low  <= cfg_data[4*DUR_W-1:0];
        REG_DUR_HIGH:   durations_pins_high <= cfg_data[4*DUR_W-1:0];
        REG_IDLE_MASK:  idle_mask           <= cfg_data[PINS_W-1:0];
        REG_TICKS_MS:   ticks_per_ms        <= cfg_data[TPM_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar n = 0; n < PINS_W; n++) begin : g_pin
    if (n < PIN_COUNT) begin : g_used
      mode_t                  mode;
      logic                   event_mode;
      logic                   hit;
      dur_t                   dur_raw;
      dur_t                   dur;
      logic [PROD_W-1:0]      prod;
      logic [CALC_W-1:0]      prod_ext;
      logic [COUNT_WIDTH-1:0] load;
      logic [COUNT_WIDTH-1:0] count;
      logic [COUNT_WIDTH-1:0] count_next;
      logic                   level_next;
      logic                   arm_next;
      event_set_t             events;

      assign mode       = mode_table[MODE_W*n +: MODE_W];
      assign event_mode = (mode >= MODE_FIRST) && (mode <= MODE_LAST);
      assign events     = mode_events(mode);
      assign hit        = events[event_code];
      assign dur_raw    = dur_all[DUR_W*n +: DUR_W];
      assign dur        = (dur_raw > MAX_DURATION_MS) ? MAX_DURATION_MS : dur_raw;
      assign prod       = PROD_W'(dur) * PROD_W'(ticks_per_ms);
      assign prod_ext   = CALC_W'(prod);
      assign load       = (|(prod_ext >> COUNT_WIDTH)) ? '1 : prod_ext[COUNT_WIDTH-1:0];

      assign levels_next[n] = level_next;
      assign armed_next[n]  = arm_next;

      always_comb begin
        level_next = levels[n];
        arm_next   = armed[n];
        count_next = count;
        unique case (action)
          ACT_TICK: begin
            if (armed[n]) begin
              if (count <= COUNT_WIDTH'(1)) begin
                count_next = '0;
                arm_next   = 1'b0;
                level_next = ~levels[n];
              end else begin
                count_next = count - COUNT_WIDTH'(1);
              end
            end
          end
          ACT_EVENT: begin
            if (hit) begin
              if (dur == '0) begin
                level_next = ~levels[n];
              end else begin
                count_next = load;
                arm_next   = 1'b1;
                level_next = ~idle_mask[n];
              end
            end
          end
          ACT_REINIT: begin
            count_next = '0;
            arm_next   = 1'b0;
            if (event_mode) begin
              level_next = idle_mask[n];
            end
          end
          default: ;
        endcase
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          count <= '0;
        end else if (in_xfer) begin
          count <= count_next;
        end
      end
    end else begin : g_absent
      assign levels_next[n] = 1'b0;
      assign armed_next[n]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '0;
      armed  <= '0;
    end else if (in_xfer) begin
      levels <= levels_next;
      armed  <= armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        pin_levels     <= levels_next;
        timers_running <= armed_next;
      end else begin
        skid_levels <= levels_next;
        skid_armed  <= armed_next;
      end
    end else if (out_xfer && skid_valid) begin
      pin_levels     <= skid_levels;
      timers_running <= skid_armed;
    end
  end

endmodule

// ===== rtl/core/etpp_checker.sv =====
// ----------------------------------------------------------------------------
// Event-triggered pin pulser port checker
// Handshake and result-buffer checks seen from the top-level ports.
// ----------------------------------------------------------------------------
module etpp_checker
  import etpp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [PINS_W-1:0] pin_levels,
  input logic [PINS_W-1:0] timers_running
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result buffer not empty after reset");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> out_valid)
    else $error("transfer into empty buffer gave no result");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pin_levels) && $stable(timers_running))
    else $error("stalled result changed");

endmodule

bind event_triggered_pin_pulser_top etpp_checker u_etpp_checker (.*);

// ===== tb/sv/event_triggered_pin_pulser_top_tb.sv =====
// ----------------------------------------------------------------------------
// Event-triggered pin pulser testbench
// Drives tick, event, reinit and no-op items through the valid/stall input
// channel, tracks pin levels, armed timers and countdowns in a local pin model,
// and compares every output transfer against the oldest predicted pin state.
// Directed cases cover reset state, mode matching, retrigger, long and zero
// durations and tick-rate extremes; random phases vary config and idling.
// ----------------------------------------------------------------------------
module event_triggered_pin_pulser_top_tb;
  import etpp_pkg::*;

  localparam int COUNT_W = 26;
  localparam int CYCLE_LIMIT = 200000;
  localparam action_t ACT_NONE = 2'd3;

  typedef struct packed {
    logic [PINS_W-1:0] levels;
    logic [PINS_W-1:0] armed;
  } pin_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ACTION_W-1:0] action = '0;
  logic [EVENT_W-1:0] event_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PINS_W-1:0] pin_levels;
  logic [PINS_W-1:0] timers_running;

  // pin model: configuration and state
  logic [47:0] cfg_modes = '0;
  logic [39:0] cfg_dur_lo = '0;
  logic [39:0] cfg_dur_hi = '0;
  logic [7:0] cfg_idle = '0;
  logic [15:0] cfg_tpm = 16'd1;
  logic [PINS_W-1:0] model_levels = '0;
  logic [PINS_W-1:0] model_armed = '0;
  logic [COUNT_W-1:0] model_countdown [8];

  pin_state_t pin_state_q [$];
  int mismatches = 0;
  int cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  event_triggered_pin_pulser_top #(
    .PIN_COUNT(8),
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .event_code(event_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pin_levels(pin_levels),
    .timers_running(timers_running)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [9:0] events_for_mode(input mode_t m);
    logic [9:0] set;
    case (m)
      6'd10: set = 10'h001;
      6'd11: set = 10'h002;
      6'd12: set = 10'h004;
      6'd13: set = 10'h003;
      6'd14: set = 10'h007;
      6'd15: set = 10'h008;
      6'd16: set = 10'h010;
      6'd17: set = 10'h020;
      6'd18: set = 10'h040;
      6'd19: set = 10'h030;
      6'd20: set = 10'h070;
      6'd21: set = 10'h011;
      6'd22: set = 10'h022;
      6'd23: set = 10'h044;
      6'd24: set = 10'h033;
      6'd25: set = 10'h077;
      6'd26: set = 10'h080;
      6'd27: set = 10'h100;
      6'd28: set = 10'h200;
      default: set = '0;
    endcase
    return set;
  endfunction

  function automatic logic [COUNT_W-1:0] pulse_ticks(input int n);
    logic [9:0] ms;
    logic [41:0] prod;
    logic [41:0] limit;
    ms = (n < 4) ? cfg_dur_lo[10*n +: 10] : cfg_dur_hi[10*(n-4) +: 10];
    if (ms > MAX_DURATION_MS) ms = MAX_DURATION_MS;
    prod = 42'(ms) * 42'(cfg_tpm);
    limit = (42'd1 << COUNT_W) - 42'd1;
    if (prod > limit) prod = limit;
    return prod[COUNT_W-1:0];
  endfunction

  // update the pin model for one accepted item and queue the resulting state
  task automatic advance_pins(input action_t act, input event_t ev);
    pin_state_t snap;
    mode_t m;
    logic [9:0] set;
    logic [COUNT_W-1:0] ticks;
    for (int n = 0; n < 8; n++) begin
      m = cfg_modes[6*n +: 6];
      set = events_for_mode(m);
      case (act)
        ACT_TICK: begin
          if (model_armed[n]) begin
            if (model_countdown[n] <= 1) begin
              model_countdown[n] = '0;
              model_armed[n] = 1'b0;
              model_levels[n] = ~model_levels[n];
            end else begin
              model_countdown[n] = model_countdown[n] - 1'b1;
            end
          end
        end
        ACT_EVENT: begin
          if (ev < 10 && set[ev[3:0]]) begin
            ticks = pulse_ticks(n);
            if (((n < 4) ? cfg_dur_lo[10*n +: 10] : cfg_dur_hi[10*(n-4) +: 10]) == 0) begin
              model_levels[n] = ~model_levels[n];
            end else begin
              model_countdown[n] = ticks;
              model_armed[n] = 1'b1;
              model_levels[n] = ~cfg_idle[n];
            end
          end
        end
        ACT_REINIT: begin
          model_countdown[n] = '0;
          model_armed[n] = 1'b0;
          if (m >= MODE_FIRST && m <= MODE_LAST) model_levels[n] = cfg_idle[n];
        end
        default: ;
      endcase
    end
    snap.levels = model_levels;
    snap.armed = model_armed;
    pin_state_q.push_back(snap);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("%0d: %s mismatch: got %h expected %h", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    pin_state_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pin_state_q.size() == 0) begin
        report_mismatch("unexpected transfer", pin_levels, 8'h00);
      end else begin
        want = pin_state_q.pop_front();
        if (pin_levels !== want.levels)
          report_mismatch("pin_levels", pin_levels, want.levels);
        if (timers_running !== want.armed)
          report_mismatch("timers_running", timers_running, want.armed);
      end
    end
  end

  task automatic send_item(input action_t act, input event_t ev);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    event_code <= ev;
    do @(posedge clk); while (in_stall);
    advance_pins(act, ev);
  endtask

  task automatic wait_for_results;
    in_valid <= 1'b0;
    while (pin_state_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE_TABLE: cfg_modes = val;
      REG_DUR_LOW:    cfg_dur_lo = val[39:0];
      REG_DUR_HIGH:   cfg_dur_hi = val[39:0];
      REG_IDLE_MASK:  cfg_idle = val[7:0];
      REG_TICKS_MS:   cfg_tpm = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_reset_values;
    send_item(ACT_TICK, 4'd0);
    send_item(ACT_EVENT, 4'd0);
    send_item(ACT_NONE, 4'hF);
    send_item(ACT_REINIT, 4'd0);
    wait_for_results;
  endtask

  task automatic test_event_modes;
    write_reg(REG_MODE_TABLE, {6'd24, 6'd0, 6'd63, 6'd20, 6'd25, 6'd14, 6'd28, 6'd10});
    write_reg(REG_DUR_LOW, {8'h00, 10'd2, 10'd1, 10'd1023, 10'd0});
    write_reg(REG_DUR_HIGH, {8'hFF, 10'd3, 10'd1, 10'd5, 10'd0});
    write_reg(REG_IDLE_MASK, 48'h0000_0000_00A5);
    write_reg(REG_TICKS_MS, 48'h0000_0000_0001);
    send_item(ACT_REINIT, 4'd0);
    send_item(ACT_EVENT, 4'd0);
    send_item(ACT_TICK, 4'd0);
    send_item(ACT_TICK, 4'd0);
    send_item(ACT_EVENT, 4'd9);
    send_item(ACT_EVENT, 4'd4);
    send_item(ACT_EVENT, 4'd5);
    send_item(ACT_EVENT, 4'd10);
    send_item(ACT_EVENT, 4'd15);
    send_item(ACT_TICK, 4'd0);
    send_item(ACT_NONE, 4'd7);
    send_item(ACT_REINIT, 4'd0);
    wait_for_results;
  endtask

  task automatic test_tick_rate_extremes;
    write_reg(REG_TICKS_MS, 48'h0000_0000_0000);
    send_item(ACT_EVENT, 4'd0);
    send_item(ACT_TICK, 4'd0);
    wait_for_results;
    write_reg(REG_TICKS_MS, 48'hFFFF_FFFF_FFFF);
    send_item(ACT_EVENT, 4'd9);
    send_item(ACT_TICK, 4'd0);
    wait_for_results;
    write_reg(REG_MODE_TABLE, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_IDLE_MASK, 48'h0000_0000_00FF);
    send_item(ACT_EVENT, 4'd0);
    send_item(ACT_REINIT, 4'd0);
    wait_for_results;
  endtask

  function automatic logic [9:0] random_duration;
    int r;
    r = $urandom_range(99);
    if (r < 15) return 10'd0;
    if (r < 75) return 10'($urandom_range(1, 4));
    if (r < 90) return 10'($urandom_range(5, 30));
    return 10'($urandom_range(990, 1023));
  endfunction

  task automatic load_random_config;
    logic [47:0] modes;
    logic [39:0] lo;
    logic [39:0] hi;
    logic [47:0] noise;
    int r;
    for (int n = 0; n < 8; n++)
      modes[6*n +: 6] = ($urandom_range(99) < 80) ? 6'($urandom_range(10, 28))
                                                 : 6'($urandom_range(0, 63));
    for (int n = 0; n < 4; n++) begin
      lo[10*n +: 10] = random_duration();
      hi[10*n +: 10] = random_duration();
    end
    write_reg(REG_MODE_TABLE, modes);
    write_reg(REG_DUR_LOW, {8'($urandom), lo});
    write_reg(REG_DUR_HIGH, {8'($urandom), hi});
    noise = 48'({$urandom, $urandom});
    r = $urandom_range(9);
    noise[7:0] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
    write_reg(REG_IDLE_MASK, noise);
    noise = 48'({$urandom, $urandom});
    r = $urandom_range(99);
    noise[15:0] = (r < 10) ? 16'd0 : (r < 80) ? 16'($urandom_range(1, 3)) :
                  (r < 90) ? 16'($urandom_range(4, 20)) :
                  (r < 95) ? 16'hFFFF : 16'($urandom);
    write_reg(REG_TICKS_MS, noise);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct);
    int r;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    for (int phase = 0; phase < 4; phase++) begin
      load_random_config();
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(99);
        if (r < 50)
          send_item(ACT_TICK, 4'($urandom));
        else if (r < 85)
          send_item(ACT_EVENT, ($urandom_range(9) == 0) ? 4'($urandom_range(10, 15))
                                                        : 4'($urandom_range(0, 9)));
        else if (r < 93)
          send_item(ACT_REINIT, 4'($urandom));
        else
          send_item(ACT_NONE, 4'($urandom));
        // hold off until the pipeline is empty now and then
        if ($urandom_range(199) == 0) wait_for_results;
      end
      wait_for_results;
    end
  endtask

  initial begin
    for (int n = 0; n < 8; n++) model_countdown[n] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values;
    test_event_modes;
    test_tick_rate_extremes;
    test_random_traffic(22, 60);
    test_random_traffic(60, 22);
    test_random_traffic(0, 0);
    wait_for_results;
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pin_state_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
